[rtl/ps2sc_pkg.sv]
// Package for the PS/2 scan code translator: scan code constants and the
// lookup request that passes from the decoder to the table stage.
// No dependencies.
`default_nettype none

package ps2sc_pkg;

    localparam int unsigned CODE_W   = 8;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned MAP_DEPTH = 512;
    localparam int unsigned MAP_AW   = $clog2(MAP_DEPTH);

    localparam logic [CODE_W-1:0] CODE_RELEASE = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_EXTEND  = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_LSHIFT  = 8'h12;
    localparam logic [CODE_W-1:0] CODE_RSHIFT  = 8'h59;
    localparam logic [CODE_W-1:0] CODE_CTRL    = 8'h14;
    localparam logic [CODE_W-1:0] CODE_ALT     = 8'h11;
    localparam logic [CODE_W-1:0] MOD_BIT      = 8'h80;
    localparam logic [CHAR_W-1:0] CTRL_MASK    = 8'h1F;

    localparam logic ACT_SCAN  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Table read for one pressed key
    typedef struct packed {
        logic                emit;
        logic [MAP_AW-1:0]   addr;
        logic                ctrl;
        logic [CODE_W-1:0]   key;
    } lookup_t;

endpackage

`default_nettype wire

[rtl/ps2sc_if.sv]
// Valid/ready channel interfaces for the scan code input and the
// character output. Depends on ps2sc_pkg.
`default_nettype none

interface ps2sc_in_if;
    import ps2sc_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [CODE_W-1:0] scan_code;
    logic              map_select;
    logic [7:0]        entry_index;
    logic [CHAR_W-1:0] entry_value;

    modport source (output valid, action, scan_code, map_select, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, action, scan_code, map_select, entry_index, entry_value,
                    output ready);
endinterface

interface ps2sc_out_if;
    import ps2sc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic [CODE_W-1:0] key_code;

    modport source (output valid, char_code, key_code, input ready);
    modport sink   (input valid, char_code, key_code, output ready);
endinterface

`default_nettype wire

[rtl/ps2sc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ps2sc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/ps2sc_decode.sv]
// Scan code decoder: release prefix and modifier flags, table address of a
// pressed key. Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      action,
    input  logic [ps2sc_pkg::CODE_W-1:0] scan_code,
    output ps2sc_pkg::lookup_t        req
);
    import ps2sc_pkg::*;

    logic release_reg, release_next;
    logic shift_reg,   shift_next;
    logic ctrl_reg,    ctrl_next;
    logic alt_reg,     alt_next;
    logic pressed;
    logic emit;
    logic [CODE_W-1:0] look;

    always_comb
    begin
        pressed      = !release_reg;
        release_next = release_reg;
        shift_next   = shift_reg;
        ctrl_next    = ctrl_reg;
        alt_next     = alt_reg;
        emit         = 1'b0;
        case (scan_code)
            CODE_RELEASE: release_next = 1'b1;
            CODE_EXTEND:  release_next = release_reg;
            CODE_LSHIFT, CODE_RSHIFT:
            begin
                shift_next   = pressed;
                release_next = 1'b0;
            end
            CODE_CTRL:
            begin
                ctrl_next    = pressed;
                release_next = 1'b0;
            end
            CODE_ALT:
            begin
                alt_next     = pressed;
                release_next = 1'b0;
            end
            default:
            begin
                release_next = 1'b0;
                emit         = pressed;
            end
        endcase
    end

    // shift or ctrl selects the upper half of each map, alt the second map
    assign look = scan_code | ((shift_reg || ctrl_reg) ? MOD_BIT : '0);

    assign req.emit = accept && (action == ACT_SCAN) && emit;
    assign req.addr = {alt_reg, look};
    assign req.ctrl = ctrl_reg;
    assign req.key  = scan_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg <= 1'b0;
            shift_reg   <= 1'b0;
            ctrl_reg    <= 1'b0;
            alt_reg     <= 1'b0;
        end
        else if (accept && (action == ACT_SCAN))
        begin
            release_reg <= release_next;
            shift_reg   <= shift_next;
            ctrl_reg    <= ctrl_next;
            alt_reg     <= alt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ps2_scancode_to_char.sv]
// PS/2 scan code set 2 translator.
// Input channel "codes": each beat is either a received scan code byte
// (action 0) or a write of one translation map entry (action 1, map_select
// picks the normal or the alt map, entry_index/entry_value give the entry).
// Output channel "chars": one beat per pressed ordinary key, carrying the
// translated character and the raw scan code. Release prefixes, extended
// prefixes, modifier keys, releases and map writes produce no beat.
// A pressed key passes through the map read register and then the output
// register before it shows on chars.
// Throughput: one input beat per cycle, sustained while chars is taken.
// When chars stalls, the table stage and the output register fill and then
// codes.ready drops; nothing is lost or repeated.
// Reset clears the release and modifier flags and empties the pipeline.
// The translation maps are not cleared: every entry must be written
// before a key that reads it is pressed.
// Depends on ps2sc_pkg, ps2sc_if, ps2sc_ram and ps2sc_decode.
`default_nettype none

module ps2_scancode_to_char (
    input  logic        clk,
    input  logic        rst_n,
    ps2sc_in_if.sink    codes,
    ps2sc_out_if.source chars
);
    import ps2sc_pkg::*;

    lookup_t           req;
    logic              accept;
    logic              advance;
    logic              rd_valid_reg;
    logic              rd_ctrl_reg;
    logic [CODE_W-1:0] rd_key_reg;
    logic [CHAR_W-1:0] rd_data;
    logic [CHAR_W-1:0] masked;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CODE_W-1:0] out_key_reg;

    // the read stage moves on when the output register is free or drained
    assign advance      = !out_valid_reg || chars.ready;
    assign codes.ready  = !rd_valid_reg || advance;
    assign accept       = codes.valid && codes.ready;

    ps2sc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (codes.action),
        .scan_code (codes.scan_code),
        .req       (req)
    );

    ps2sc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (accept && (codes.action == ACT_WRITE)),
        .waddr ({codes.map_select, codes.entry_index}),
        .wdata (codes.entry_value),
        .re    (req.emit),
        .raddr (req.addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (codes.ready)
            begin
                rd_valid_reg <= req.emit;
            end
            if (advance)
            begin
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.emit)
        begin
            rd_ctrl_reg <= req.ctrl;
            rd_key_reg  <= req.key;
        end
        if (advance && rd_valid_reg)
        begin
            out_char_reg <= masked;
            out_key_reg  <= rd_key_reg;
        end
    end

    assign masked = rd_ctrl_reg ? (rd_data & CTRL_MASK) : rd_data;

    assign chars.valid     = out_valid_reg;
    assign chars.char_code = out_char_reg;
    assign chars.key_code  = out_key_reg;

endmodule

`default_nettype wire
